>>> design/csc_pkg.sv
// Package for the three-point circumcenter block.
// Widths, payload structs and limits; used by every design file.
package csc_pkg;

	localparam int CW   = 24;                       // coordinate width
	localparam int DW   = CW + 1;                   // differences and sums
	localparam int PW   = 2 * DW;                   // first products
	localparam int EW   = PW + 1;                   // e2, f2, det
	localparam int LO   = EW - DW;                  // low split of e2/f2
	localparam int HPW  = 2 * DW;                   // hi partial product
	localparam int LPW  = DW + LO + 1;              // lo partial product
	localparam int NW   = DW + EW + 1;              // numerators
	localparam int DNW  = EW + 1;                   // denominator 2*|det|
	localparam int QW   = 32;                       // quotient / output
	localparam int DMW  = 48;                       // threshold register
	localparam int CMPW = (EW > DMW) ? EW : DMW;
	localparam int TW   = ((NW > DNW + QW) ? NW : DNW + QW) + 1;

	localparam logic [QW-1:0] MAXV = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] MINV = {1'b1, {(QW-1){1'b0}}};
	localparam logic [DMW-1:0] DET_MIN_RST = DMW'(1);

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by_coord;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
	} in_t;

	typedef struct packed {
		logic signed [QW-1:0] center_x;
		logic signed [QW-1:0] center_y;
		logic                 found;
		logic                 saturated;
	} out_t;

	typedef struct packed {
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic signed [DW-1:0] c;
		logic signed [DW-1:0] d;
		logic signed [EW-1:0] e2;
		logic signed [EW-1:0] f2;
		logic signed [EW-1:0] det;
	} front_t;

	typedef struct packed {
		logic [NW-1:0]  num;
		logic [DNW-1:0] den;
		logic           neg;
		logic           ovf;
	} div_in_t;

	typedef struct packed {
		logic [QW-1:0] value;
		logic          sat;
	} div_out_t;

endpackage

>>> design/csc_front.sv
// Front stages s1..s3: differences, products, e2/f2/det.
// Depends on csc_pkg.
module csc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  csc_pkg::in_t     din,
	output logic             v_s3,
	output csc_pkg::front_t  dout
);
	localparam int DW = csc_pkg::DW;
	localparam int PW = csc_pkg::PW;
	localparam int CW = csc_pkg::CW;

	logic v_s1, v_s2;
	logic signed [DW-1:0] a_s1, b_s1, c_s1, d_s1, sab_s1, sbb_s1, sac_s1, sbc_s1;
	logic signed [DW-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pbc_s2, pad_s2;
	csc_pkg::front_t f_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= {din.ax[CW-1], din.ax} - {din.bx[CW-1], din.bx};
			b_s1   <= {din.ay[CW-1], din.ay} - {din.by_coord[CW-1], din.by_coord};
			c_s1   <= {din.ax[CW-1], din.ax} - {din.px[CW-1], din.px};
			d_s1   <= {din.ay[CW-1], din.ay} - {din.py[CW-1], din.py};
			sab_s1 <= {din.ax[CW-1], din.ax} + {din.bx[CW-1], din.bx};
			sbb_s1 <= {din.ay[CW-1], din.ay} + {din.by_coord[CW-1], din.by_coord};
			sac_s1 <= {din.ax[CW-1], din.ax} + {din.px[CW-1], din.px};
			sbc_s1 <= {din.ay[CW-1], din.ay} + {din.py[CW-1], din.py};

			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			d_s2   <= d_s1;
			pa_s2  <= a_s1 * sab_s1;
			pb_s2  <= b_s1 * sbb_s1;
			pc_s2  <= c_s1 * sac_s1;
			pd_s2  <= d_s1 * sbc_s1;
			pbc_s2 <= b_s1 * c_s1;
			pad_s2 <= a_s1 * d_s1;

			f_s3.a   <= a_s2;
			f_s3.b   <= b_s2;
			f_s3.c   <= c_s2;
			f_s3.d   <= d_s2;
			f_s3.e2  <= {pa_s2[PW-1], pa_s2} + {pb_s2[PW-1], pb_s2};
			f_s3.f2  <= {pc_s2[PW-1], pc_s2} + {pd_s2[PW-1], pd_s2};
			f_s3.det <= {pbc_s2[PW-1], pbc_s2} - {pad_s2[PW-1], pad_s2};
		end
	end

	assign dout = f_s3;
endmodule

>>> design/csc_numer.sv
// Stages s4..s6: split products for the numerators, threshold test,
// magnitudes and quotient overflow check. Depends on csc_pkg.
module csc_numer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    v_in,
	input  csc_pkg::front_t         fin,
	input  logic [csc_pkg::DMW-1:0] det_min,
	output logic                    v_s6,
	output logic                    found_s6,
	output csc_pkg::div_in_t        dx,
	output csc_pkg::div_in_t        dy
);
	localparam int DW   = csc_pkg::DW;
	localparam int EW   = csc_pkg::EW;
	localparam int LO   = csc_pkg::LO;
	localparam int HPW  = csc_pkg::HPW;
	localparam int LPW  = csc_pkg::LPW;
	localparam int NW   = csc_pkg::NW;
	localparam int DNW  = csc_pkg::DNW;
	localparam int QW   = csc_pkg::QW;
	localparam int TW   = csc_pkg::TW;
	localparam int CMPW = csc_pkg::CMPW;

	logic v_s4, v_s5;
	logic found_s4, found_s5;
	logic dneg_s4, dneg_s5;
	logic signed [HPW-1:0] p1_s4, p3_s4, p5_s4, p7_s4;
	logic signed [LPW-1:0] p2_s4, p4_s4, p6_s4, p8_s4;
	logic [EW-1:0] dabs_s4;
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic [DNW-1:0] den_s5;

	logic signed [DW-1:0] e2h, f2h;
	logic signed [LO:0]   e2l, f2l;
	logic [EW-1:0] dabs;
	logic signed [HPW:0] hx, hy;
	logic signed [LPW:0] lx, ly;
	logic [NW-1:0] ax_abs, ay_abs;

	always_comb begin
		e2h  = fin.e2[EW-1:LO];
		f2h  = fin.f2[EW-1:LO];
		e2l  = {1'b0, fin.e2[LO-1:0]};
		f2l  = {1'b0, fin.f2[LO-1:0]};
		dabs = fin.det[EW-1] ? EW'(-fin.det) : EW'(fin.det);
		hx   = {p1_s4[HPW-1], p1_s4} - {p3_s4[HPW-1], p3_s4};
		hy   = {p5_s4[HPW-1], p5_s4} - {p7_s4[HPW-1], p7_s4};
		lx   = {p2_s4[LPW-1], p2_s4} - {p4_s4[LPW-1], p4_s4};
		ly   = {p6_s4[LPW-1], p6_s4} - {p8_s4[LPW-1], p8_s4};
		ax_abs = nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
		ay_abs = ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// nx = b*f2 - d*e2, ny = c*e2 - a*f2, with e2 and f2 split hi/lo
			p1_s4 <= fin.b * f2h;
			p2_s4 <= fin.b * f2l;
			p3_s4 <= fin.d * e2h;
			p4_s4 <= fin.d * e2l;
			p5_s4 <= fin.c * e2h;
			p6_s4 <= fin.c * e2l;
			p7_s4 <= fin.a * f2h;
			p8_s4 <= fin.a * f2l;
			dabs_s4  <= dabs;
			dneg_s4  <= fin.det[EW-1];
			// zero det is collinear even with a zero threshold
			found_s4 <= (fin.det != '0) && (CMPW'(dabs) >= CMPW'(det_min));

			nx_s5    <= (NW'(hx) <<< LO) + NW'(lx);
			ny_s5    <= (NW'(hy) <<< LO) + NW'(ly);
			den_s5   <= {dabs_s4, 1'b0};
			dneg_s5  <= dneg_s4;
			found_s5 <= found_s4;

			// quotient sign: numerator sign against determinant sign
			dx.num   <= ax_abs;
			dx.den   <= den_s5;
			dx.neg   <= nx_s5[NW-1] ^ dneg_s5;
			dx.ovf   <= TW'(ax_abs) >= (TW'(den_s5) << QW);
			dy.num   <= ay_abs;
			dy.den   <= den_s5;
			dy.neg   <= ny_s5[NW-1] ^ dneg_s5;
			dy.ovf   <= TW'(ay_abs) >= (TW'(den_s5) << QW);
			found_s6 <= found_s5;
		end
	end
endmodule

>>> design/csc_div.sv
// Restoring divider, one quotient bit per pipeline stage, with
// signed saturation on the result. Depends on csc_pkg.
module csc_div (
	input  logic              clk,
	input  logic              en,
	input  csc_pkg::div_in_t  din,
	output csc_pkg::div_out_t dout
);
	localparam int NW  = csc_pkg::NW;
	localparam int DNW = csc_pkg::DNW;
	localparam int QW  = csc_pkg::QW;
	localparam int TW  = csc_pkg::TW;

	logic [NW-1:0]  rem_d [QW];
	logic [DNW-1:0] den_d [QW];
	logic [QW-1:0]  q_d   [QW];
	logic           neg_d [QW];
	logic           ovf_d [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			localparam int SH = QW - 1 - k;
			logic [NW-1:0]  rem_i;
			logic [DNW-1:0] den_i;
			logic [QW-1:0]  q_i;
			logic           neg_i, ovf_i;
			logic [TW-1:0]  trial;

			if (k == 0) begin : g_first
				assign rem_i = din.num;
				assign den_i = din.den;
				assign q_i   = '0;
				assign neg_i = din.neg;
				assign ovf_i = din.ovf;
			end else begin : g_next
				assign rem_i = rem_d[k-1];
				assign den_i = den_d[k-1];
				assign q_i   = q_d[k-1];
				assign neg_i = neg_d[k-1];
				assign ovf_i = ovf_d[k-1];
			end

			assign trial = TW'(rem_i) - (TW'(den_i) << SH);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_d[k] <= trial[TW-1] ? rem_i : trial[NW-1:0];
					q_d[k]   <= q_i | (QW'(!trial[TW-1]) << SH);
					den_d[k] <= den_i;
					neg_d[k] <= neg_i;
					ovf_d[k] <= ovf_i;
				end
			end
		end
	endgenerate

	logic [QW-1:0] q;
	logic          neg, big;

	always_comb begin
		q    = q_d[QW-1];
		neg  = neg_d[QW-1];
		big  = neg ? (q > csc_pkg::MINV) : q[QW-1];
		dout.sat = ovf_d[QW-1] || big;
		if (dout.sat) begin
			dout.value = neg ? csc_pkg::MINV : csc_pkg::MAXV;
		end else begin
			dout.value = neg ? (QW'(0) - q) : q;
		end
	end
endmodule

>>> design/three_point_circumcenter_top.sv
// Circumcenter of three points: each input beat flows to the result through
// 3 front stages, 3 numerator stages, 32 divider stages, output register.
// One beat per cycle unless out_ready stalls; the divider sets the depth.
// Reset clears all valid bits and sets det_min to 1; data regs are not reset.
// Depends on csc_pkg, csc_front, csc_numer, csc_div.
module three_point_circumcenter_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  csc_pkg::in_t            in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output csc_pkg::out_t           out_data,
	input  logic                    det_min_we,
	input  logic [csc_pkg::DMW-1:0] det_min_wdata
);
	localparam int QW = csc_pkg::QW;

	logic [csc_pkg::DMW-1:0] det_min_q;
	logic                    en;
	logic                    v_s3, v_s6, found_s6;
	csc_pkg::front_t         fr;
	csc_pkg::div_in_t        dx, dy;
	csc_pkg::div_out_t       rx, ry;

	// valid and found ride alongside the divider stages
	logic v_d [QW];
	logic f_d [QW];

	csc_pkg::out_t out_q;
	logic          out_valid_q;

	// whole pipe advances unless the output register holds an untaken beat
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_min_q <= csc_pkg::DET_MIN_RST;
		end else if (det_min_we) begin
			det_min_q <= det_min_wdata;
		end
	end

	csc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (in_valid),
		.din    (in_data),
		.v_s3   (v_s3),
		.dout   (fr)
	);

	csc_numer u_numer (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s3),
		.fin      (fr),
		.det_min  (det_min_q),
		.v_s6     (v_s6),
		.found_s6 (found_s6),
		.dx       (dx),
		.dy       (dy)
	);

	csc_div u_div_x (
		.clk  (clk),
		.en   (en),
		.din  (dx),
		.dout (rx)
	);

	csc_div u_div_y (
		.clk  (clk),
		.en   (en),
		.din  (dy),
		.dout (ry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) begin
				v_d[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_d[0] <= v_s6;
			for (int i = 1; i < QW; i++) begin
				v_d[i] <= v_d[i-1];
			end
			out_valid_q <= v_d[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_d[0] <= found_s6;
			for (int i = 1; i < QW; i++) begin
				f_d[i] <= f_d[i-1];
			end
			// collinear: all result fields but found stay zero
			out_q.found     <= f_d[QW-1];
			out_q.center_x  <= f_d[QW-1] ? rx.value : '0;
			out_q.center_y  <= f_d[QW-1] ? ry.value : '0;
			out_q.saturated <= f_d[QW-1] && (rx.sat || ry.sat);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_collinear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |->
			out_data.center_x == '0 && out_data.center_y == '0 && !out_data.saturated)
		else $error("collinear beat carries nonzero center");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			out_data.center_x == csc_pkg::MAXV || out_data.center_x == csc_pkg::MINV ||
			out_data.center_y == csc_pkg::MAXV || out_data.center_y == csc_pkg::MINV)
		else $error("saturated flag without a clipped coordinate");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v_d[QW-1]) && $stable(f_d[QW-1]))
		else $error("divider tail moved during output stall");
endmodule

>>> sim/three_point_circumcenter_top_tb.sv
`timescale 1ns / 1ps
// Testbench for three_point_circumcenter_top: directed and random point triples,
// predicted centers checked beat by beat. Depends on csc_pkg and the design files.
module three_point_circumcenter_top_tb;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	csc_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	csc_pkg::out_t out_data;
	logic det_min_we;
	logic [csc_pkg::DMW-1:0] det_min_wdata;

	three_point_circumcenter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.det_min_we(det_min_we), .det_min_wdata(det_min_wdata)
	);

	// Pending triples for the driver, predicted centers for the monitor.
	csc_pkg::in_t triple_q[$];
	csc_pkg::out_t center_q[$];
	logic [csc_pkg::DMW-1:0] thresh;      // model copy of det_min
	int mismatches = 0;
	int idle_pct = 35;           // idle odds in percent, both sides
	bit hold_off = 0;            // sender pause requested by the stimulus

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Exact circumcenter in 128-bit signed math, truncated toward zero.
	function automatic csc_pkg::out_t circumcenter(csc_pkg::in_t t,
			logic [csc_pkg::DMW-1:0] lim);
		logic signed [127:0] x1, y1, x2, y2, x3, y3, a, b, c, d, e2, f2, det;
		logic signed [127:0] den, nx, ny, mag;
		logic signed [127:0] qx, qy;
		csc_pkg::out_t r;
		x1 = t.ax; y1 = t.ay; x2 = t.bx; y2 = t.by_coord; x3 = t.px; y3 = t.py;
		a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
		e2 = a * (x1 + x2) + b * (y1 + y2);
		f2 = c * (x1 + x3) + d * (y1 + y3);
		det = b * c - a * d;
		r = '0;
		mag = (det < 0) ? -det : det;
		if (det == 0 || mag < $signed({80'd0, lim}))
			return r;
		den = det + det;
		nx = b * f2 - d * e2;
		ny = c * e2 - a * f2;
		qx = nx / den;           // SV signed division truncates toward zero
		qy = ny / den;
		r.found = 1'b1;
		if (qx > 128'sd2147483647) begin
			r.center_x = csc_pkg::MAXV; r.saturated = 1'b1;
		end else if (qx < -128'sd2147483648) begin
			r.center_x = csc_pkg::MINV; r.saturated = 1'b1;
		end else
			r.center_x = qx[31:0];
		if (qy > 128'sd2147483647) begin
			r.center_y = csc_pkg::MAXV; r.saturated = 1'b1;
		end else if (qy < -128'sd2147483648) begin
			r.center_y = csc_pkg::MINV; r.saturated = 1'b1;
		end else
			r.center_y = qy[31:0];
		return r;
	endfunction

	// Driver: one beat per accepted handshake, random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				center_q.push_back(circumcenter(in_data, thresh));
			end
			if (!in_valid || in_ready) begin
				if (triple_q.size() > 0 && !hold_off
						&& $urandom_range(99, 0) >= idle_pct) begin
					in_valid <= 1;
					in_data <= triple_q.pop_front();
				end else
					in_valid <= 0;
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (center_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", out_data);
				end else begin
					csc_pkg::out_t want;
					want = center_q.pop_front();
					if (want !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", want, out_data);
					end
				end
			end
			out_ready <= ($urandom_range(99, 0) >= idle_pct);
		end
	end

	function automatic logic signed [csc_pkg::CW-1:0] rnd_coord(int mode);
		case (mode)
			0: return csc_pkg::CW'($urandom_range(255, 0) - 128);        // tiny
			1: return csc_pkg::CW'($urandom_range(65535, 0) - 32768);    // medium range
			default: return csc_pkg::CW'($urandom());                    // full range
		endcase
	endfunction

	function automatic csc_pkg::in_t rnd_triple();
		csc_pkg::in_t t;
		int m;
		m = $urandom_range(2, 0);
		t.ax = rnd_coord(m); t.ay = rnd_coord(m);
		t.bx = rnd_coord(m); t.by_coord = rnd_coord(m);
		t.px = rnd_coord(m); t.py = rnd_coord(m);
		case ($urandom_range(9, 0))
			0: begin t.bx = t.ax; t.by_coord = t.ay; end        // coincident points
			1: begin                                            // collinear on a line
				t.px = csc_pkg::CW'(t.ax + 2 * (t.bx - t.ax));
				t.py = csc_pkg::CW'(t.ay + 2 * (t.by_coord - t.ay));
			end
			2: begin                                            // thin triangle
				t.px = csc_pkg::CW'(t.bx + 1);
				t.py = t.by_coord;
			end
			default: ;
		endcase
		return t;
	endfunction

	task automatic drain();
		wait (triple_q.size() == 0 && !in_valid && center_q.size() == 0);
		repeat (50) @(posedge clk);   // covers the pipe
	endtask

	task automatic set_thresh(logic [csc_pkg::DMW-1:0] v);
		@(posedge clk);
		det_min_we <= 1;
		det_min_wdata <= v;
		thresh = v;
		@(posedge clk);
		det_min_we <= 0;
	endtask

	localparam logic signed [csc_pkg::CW-1:0] CMAX = {1'b0, {(csc_pkg::CW-1){1'b1}}};
	localparam logic signed [csc_pkg::CW-1:0] CMIN = {1'b1, {(csc_pkg::CW-1){1'b0}}};
	localparam logic signed [csc_pkg::CW-1:0] CMIN_P1 = CMIN + csc_pkg::CW'(1);
	localparam logic signed [csc_pkg::CW-1:0] CMAX_M1 = CMAX - csc_pkg::CW'(1);

	initial begin
		csc_pkg::in_t t;
		arst_n = 0;
		det_min_we = 0;
		det_min_wdata = '0;
		thresh = csc_pkg::DET_MIN_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, coincident, collinear, saturating centers.
		t = '{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}; triple_q.push_back(t);
		t = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX}; triple_q.push_back(t);
		t = '{0, 0, 0, 0, 0, 0}; triple_q.push_back(t);
		t = '{0, 0, 256, 0, 0, 256}; triple_q.push_back(t);
		t = '{0, 0, 256, 256, 512, 512}; triple_q.push_back(t);
		t = '{CMIN, 0, CMAX, 0, CMAX, 1}; triple_q.push_back(t);
		t = '{CMIN, CMIN, CMAX, CMIN, CMAX, CMIN_P1}; triple_q.push_back(t);
		t = '{CMAX, CMAX, CMIN, CMAX, CMIN, CMAX_M1}; triple_q.push_back(t);
		t = '{0, 0, 1, 0, 0, 1}; triple_q.push_back(t);
		t = '{-1, -1, 1, 1, 1, -1}; triple_q.push_back(t);
		t = '{CMAX, 0, CMIN, 0, 0, CMAX}; triple_q.push_back(t);
		t = '{0, CMIN, 0, CMAX, CMIN, 0}; triple_q.push_back(t);
		drain();

		// det_min of zero: a zero determinant must still be collinear.
		set_thresh('0);
		t = '{5, 5, 5, 5, 9, 9}; triple_q.push_back(t);
		t = '{0, 0, 1, 0, 0, 1}; triple_q.push_back(t);
		for (int i = 0; i < 300; i++) triple_q.push_back(rnd_triple());
		drain();

		// Pause until drained (done above) then threshold at its top.
		set_thresh('1);
		t = '{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}; triple_q.push_back(t);
		for (int i = 0; i < 200; i++) triple_q.push_back(rnd_triple());
		drain();

		// Random thresholds, with one long stretch of no idling.
		for (int ph = 0; ph < 4; ph++) begin
			set_thresh(csc_pkg::DMW'({$urandom(), $urandom()} >> $urandom_range(47, 0)));
			idle_pct = (ph == 2) ? 0 : 35;
			for (int i = 0; i < 225; i++) triple_q.push_back(rnd_triple());
			if (ph == 1) begin
				// sender hold-off mid-stream until every result is back
				wait (triple_q.size() < 100);
				hold_off = 1;
				wait (center_q.size() == 0 && !in_valid);
				repeat (50) @(posedge clk);
				hold_off = 0;
			end
			drain();
		end
		idle_pct = 35;

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
